### hdl/assert_macros.svh
// assertion macros shared by the fifo_with_indexed_discard rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CHK_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define CHK_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hdl/fdq_pkg.sv
// shared types and codes for the fifo with indexed discard
`timescale 1ns / 1ps

package fdq_pkg;

  typedef enum logic [1:0] {
    OP_ENQ     = 2'd0,
    OP_DEQ     = 2'd1,
    OP_DISCARD = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
    logic [3:0]         position;
  } req_t;

  typedef struct packed {
    logic signed [31:0] front_value;
    logic [4:0]         count;
    logic               is_empty;
    status_t            status;
  } rsp_t;

  // storage update controls from the decision logic
  typedef struct packed {
    logic wr_en;
    logic shift_en;
  } store_ctl_t;

endpackage

### hdl/fdq_ctrl.sv
// request decode: status, new element count and storage controls
`timescale 1ns / 1ps

module fdq_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                         valid,
  input  fdq_pkg::op_t                 op,
  input  logic [3:0]                   position,
  input  logic [$clog2(DEPTH+1)-1:0]   held,
  output fdq_pkg::store_ctl_t          ctl,
  output logic [$clog2(DEPTH)-1:0]     shift_idx,
  output logic [$clog2(DEPTH)-1:0]     wr_idx,
  output logic [$clog2(DEPTH+1)-1:0]   held_next,
  output fdq_pkg::status_t             status
);
  import fdq_pkg::*;

  localparam int HELD_W = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CMP_W  = (HELD_W > 4) ? HELD_W : 4;

  logic [CMP_W-1:0] held_ext;
  logic [CMP_W-1:0] pos_ext;

  assign held_ext = CMP_W'(held);
  assign pos_ext  = CMP_W'(position);
  assign wr_idx   = held[IDX_W-1:0];

  always_comb begin
    ctl       = '0;
    shift_idx = '0;
    held_next = held;
    status    = ST_OK;
    if (valid) begin
      case (op)
        OP_ENQ: begin
          if (held == HELD_W'(DEPTH)) begin
            status = ST_FULL;
          end else begin
            ctl.wr_en = 1'b1;
            held_next = held + HELD_W'(1);
          end
        end
        OP_DEQ: begin
          if (held == '0) begin
            status = ST_EMPTY;
          end else begin
            ctl.shift_en = 1'b1;
            held_next    = held - HELD_W'(1);
          end
        end
        OP_DISCARD: begin
          if (pos_ext >= held_ext) begin
            status = ST_RANGE;
          end else begin
            ctl.shift_en = 1'b1;
            shift_idx    = pos_ext[IDX_W-1:0];
            held_next    = held - HELD_W'(1);
          end
        end
        default: begin
          // query leaves everything as it is
        end
      endcase
    end
  end

endmodule

### hdl/fdq_store.sv
// element storage: row of slots with append and one-place close-up shift
`timescale 1ns / 1ps

module fdq_store #(
  parameter int DEPTH      = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                      clk,
  input  fdq_pkg::store_ctl_t       ctl,
  input  logic [$clog2(DEPTH)-1:0]  shift_idx,
  input  logic [$clog2(DEPTH)-1:0]  wr_idx,
  input  logic [ELEM_WIDTH-1:0]     wr_data,
  output logic [ELEM_WIDTH-1:0]     head_next
);
  import fdq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  logic [ELEM_WIDTH-1:0] slot      [DEPTH];
  logic [ELEM_WIDTH-1:0] slot_next [DEPTH];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_next[i] = slot[i];
      // every slot at or past the gap, except the last, takes its neighbor's element
      if (ctl.shift_en && (IDX_W'(i) >= shift_idx) && (i < DEPTH - 1)) begin
        slot_next[i] = slot[(i + 1) % DEPTH];
      end
      if (ctl.wr_en && (IDX_W'(i) == wr_idx)) begin
        slot_next[i] = wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      slot[i] <= slot_next[i];
    end
  end

  assign head_next = slot_next[0];

endmodule

### hdl/fifo_with_indexed_discard.sv
// top level: bounded fifo of elements with discard at an index from the front
`timescale 1ns / 1ps
`include "assert_macros.svh"

// A request (enqueue, dequeue, discard at position, or query) is taken on any
// clock edge where start is high; busy never rises, so one transaction can be
// issued every cycle. The request lands in an input register, is decided and
// applied to the storage in the following cycle, and its result is presented
// on rsp with done high for exactly one cycle. The receiver cannot stall: done
// is a strobe and rsp is only valid with it. Throughput is one request per
// clock, since the whole slot row is updated at once, where a discard moves
// every later element one place forward in parallel. Results report the
// queue as it stands after the request: front element (zero when empty),
// element count, empty flag and a status code. Refused requests (enqueue when
// full, dequeue when empty, discard at or past the count) change nothing and
// carry their status code.

module fifo_with_indexed_discard #(
  parameter int DEPTH      = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  fdq_pkg::req_t req,
  output logic          done,
  output fdq_pkg::rsp_t rsp
);
  import fdq_pkg::*;

  localparam int HELD_W = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int FW     = (ELEM_WIDTH > 32) ? ELEM_WIDTH : 32;
  localparam int CW     = (HELD_W > 5) ? HELD_W : 5;

  // input register
  logic                  in_valid;
  req_t                  req_q;

  // queue state
  logic [HELD_W-1:0]     held;
  logic [HELD_W-1:0]     held_next;

  // decision outputs
  store_ctl_t            ctl;
  logic [IDX_W-1:0]      shift_idx;
  logic [IDX_W-1:0]      wr_idx;
  status_t               status;

  // element paths
  logic [FW-1:0]         val_wide;
  logic [ELEM_WIDTH-1:0] wr_data;
  logic [ELEM_WIDTH-1:0] head_next;
  logic [FW-1:0]         head_wide;
  logic [CW-1:0]         count_wide;
  rsp_t                  rsp_next;

  // never held off: the pipeline takes a transaction every cycle
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req_q <= req;
    end
  end

  // stored elements keep the low ELEM_WIDTH bits, upper bits zero when wider
  assign val_wide = FW'($unsigned(req_q.value));
  assign wr_data  = val_wide[ELEM_WIDTH-1:0];

  fdq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .valid     (in_valid),
    .op        (req_q.op),
    .position  (req_q.position),
    .held      (held),
    .ctl       (ctl),
    .shift_idx (shift_idx),
    .wr_idx    (wr_idx),
    .held_next (held_next),
    .status    (status)
  );

  fdq_store #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_store (
    .clk       (clk),
    .ctl       (ctl),
    .shift_idx (shift_idx),
    .wr_idx    (wr_idx),
    .wr_data   (wr_data),
    .head_next (head_next)
  );

  // result reflects the state after this request
  assign head_wide  = FW'(head_next);
  assign count_wide = CW'(held_next);

  always_comb begin
    rsp_next.front_value = (held_next == '0) ? '0 : head_wide[31:0];
    rsp_next.count       = count_wide[4:0];
    rsp_next.is_empty    = (held_next == '0);
    rsp_next.status      = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
      done <= 1'b0;
    end else begin
      held <= held_next;
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      rsp <= rsp_next;
    end
  end

  // count never passes capacity
  `CHK_IMP(a_held_bound, clk, rst, 1'b1, held <= HELD_W'(DEPTH))
  // every registered request yields exactly one result strobe next cycle
  `CHK_NXT(a_done_follows, clk, rst, in_valid, done)
  // empty flag agrees with the element count held
  `CHK_IMP(a_empty_flag, clk, rst, done, rsp.is_empty == (held == '0))
  // a refused enqueue only happens at capacity
  `CHK_IMP(a_full_status, clk, rst, done && (rsp.status == ST_FULL), held == HELD_W'(DEPTH))
  // no request in flight leaves the count alone
  `CHK_NXT(a_idle_stable, clk, rst, !in_valid, $stable(held))

endmodule
